// ===== src/sbx_pkg.sv =====
package sbx_pkg;

	localparam int DEF_BITS_PER_BYTE = 8;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_MASTER_MODE = 2'd0;
	localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [1:0] REG_TIMEOUT     = 2'd2;

	localparam logic        RST_MASTER_MODE = 1'b0;
	localparam logic [15:0] RST_HALF_PERIOD = 16'd64;
	localparam logic [15:0] RST_TIMEOUT     = 16'd256;

	localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  send_byte;
		logic        sin_level;
		logic        sck_level;
	} item_t;

	typedef struct packed {
		logic        sout_level;
		logic        sck_drive;
		logic        busy_res;
		logic        done_res;
		logic [7:0]  rx_byte;
		logic        timed_out;
	} res_t;

	typedef struct packed {
		logic        master_mode;
		logic [15:0] half_period_ticks;
		logic [15:0] timeout_ticks;
	} cfg_t;

endpackage

// ===== src/sbx_apb_regs.sv =====
module sbx_apb_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbx_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sbx_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sbx_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output sbx_pkg::cfg_t                    cfg
);

	sbx_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_mode       <= sbx_pkg::RST_MASTER_MODE;
			cfg_q.half_period_ticks <= sbx_pkg::RST_HALF_PERIOD;
			cfg_q.timeout_ticks     <= sbx_pkg::RST_TIMEOUT;
		end else if (wr_en) begin
			case (reg_idx)
				sbx_pkg::REG_MASTER_MODE: cfg_q.master_mode       <= pwdata[0];
				sbx_pkg::REG_HALF_PERIOD: cfg_q.half_period_ticks <= pwdata[15:0];
				sbx_pkg::REG_TIMEOUT:     cfg_q.timeout_ticks     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sbx_pkg::REG_MASTER_MODE:
				prdata = {{(sbx_pkg::APB_DATA_W-1){1'b0}}, cfg_q.master_mode};
			sbx_pkg::REG_HALF_PERIOD:
				prdata = {{(sbx_pkg::APB_DATA_W-16){1'b0}}, cfg_q.half_period_ticks};
			sbx_pkg::REG_TIMEOUT:
				prdata = {{(sbx_pkg::APB_DATA_W-16){1'b0}}, cfg_q.timeout_ticks};
			default:
				prdata = '0;
		endcase
	end

endmodule

// ===== src/sbx_xfer_engine.sv =====
module sbx_xfer_engine #(
	parameter int BITS_PER_BYTE = sbx_pkg::DEF_BITS_PER_BYTE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  sbx_pkg::item_t item,
	input  sbx_pkg::cfg_t  cfg,
	output sbx_pkg::res_t  res
);

	localparam int IDX_W = $clog2(BITS_PER_BYTE + 1);
	localparam int EXT_W = (BITS_PER_BYTE > 8) ? BITS_PER_BYTE : 8;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS_PER_BYTE - 1);

	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_M_LOW       = 3'd1;
	localparam logic [2:0] PH_M_HIGH      = 3'd2;
	localparam logic [2:0] PH_S_WAIT_LOW  = 3'd3;
	localparam logic [2:0] PH_S_WAIT_HIGH = 3'd4;

	logic [2:0]               phase_q, phase_d;
	logic [BITS_PER_BYTE-1:0] tx_q, tx_d;
	logic [BITS_PER_BYTE-1:0] rx_q, rx_d;
	logic [IDX_W-1:0]         idx_q, idx_d;
	logic [15:0]              tick_q, tick_d;
	logic                     sout_q, sout_d;
	logic                     done, tmo;
	logic [7:0]               rbyte;
	logic [BITS_PER_BYTE-1:0] tx_send;
	logic [BITS_PER_BYTE-1:0] rx_sampled;
	logic [EXT_W-1:0]         rx_ext;
	logic                     last_bit;

	assign tx_send    = BITS_PER_BYTE'(item.send_byte);
	assign rx_sampled = (rx_q << 1) | BITS_PER_BYTE'(item.sin_level);
	assign rx_ext     = EXT_W'(rx_q);
	assign last_bit   = (idx_q == LAST_IDX);

	always_comb begin
		phase_d = phase_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		idx_d   = idx_q;
		tick_d  = tick_q;
		sout_d  = sout_q;
		done    = 1'b0;
		tmo     = 1'b0;
		rbyte   = '0;
		case (phase_q)
			PH_IDLE: begin
				if (item.kind) begin
					tx_d  = tx_send;
					rx_d  = '0;
					idx_d = '0;
					if (cfg.master_mode) begin
						sout_d  = tx_send[BITS_PER_BYTE-1];
						phase_d = PH_M_LOW;
						tick_d  = 16'd1;
					end else begin
						phase_d = PH_S_WAIT_LOW;
						tick_d  = '0;
					end
				end
			end
			PH_M_LOW: begin
				if (tick_q >= cfg.half_period_ticks) begin
					rx_d    = rx_sampled;
					phase_d = PH_M_HIGH;
					tick_d  = 16'd1;
				end else begin
					tick_d = tick_q + 16'd1;
				end
			end
			PH_M_HIGH: begin
				if (tick_q >= cfg.half_period_ticks) begin
					idx_d = idx_q + IDX_W'(1);
					tx_d  = tx_q << 1;
					if (last_bit) begin
						done    = 1'b1;
						rbyte   = rx_ext[7:0];
						phase_d = PH_IDLE;
						tick_d  = '0;
					end else begin
						sout_d  = tx_q[BITS_PER_BYTE-2 >= 0 ? BITS_PER_BYTE-2 : 0]
						          & (BITS_PER_BYTE > 1);
						phase_d = PH_M_LOW;
						tick_d  = 16'd1;
					end
				end else begin
					tick_d = tick_q + 16'd1;
				end
			end
			PH_S_WAIT_LOW, PH_S_WAIT_HIGH: begin
				if (phase_q == PH_S_WAIT_LOW && !item.sck_level) begin
					rx_d    = rx_sampled;
					sout_d  = tx_q[BITS_PER_BYTE-1];
					phase_d = PH_S_WAIT_HIGH;
					tick_d  = '0;
				end else if (phase_q == PH_S_WAIT_HIGH && item.sck_level) begin
					idx_d = idx_q + IDX_W'(1);
					tx_d  = tx_q << 1;
					if (last_bit) begin
						done    = 1'b1;
						rbyte   = rx_ext[7:0];
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_S_WAIT_LOW;
					end
					tick_d = '0;
				end else if (tick_q >= cfg.timeout_ticks) begin
					done    = 1'b1;
					tmo     = 1'b1;
					rbyte   = sbx_pkg::TIMEOUT_BYTE;
					phase_d = PH_IDLE;
					tick_d  = '0;
				end else begin
					tick_d = tick_q + 16'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase

		res.sout_level = sout_d;
		res.sck_drive  = (phase_d != PH_M_LOW);
		res.busy_res   = (phase_d != PH_IDLE);
		res.done_res   = done;
		res.rx_byte    = rbyte;
		res.timed_out  = tmo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tx_q    <= '0;
			rx_q    <= '0;
			idx_q   <= '0;
			tick_q  <= '0;
			sout_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			idx_q   <= idx_d;
			tick_q  <= tick_d;
			sout_q  <= sout_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (tick_q == '0 || $past(phase_q) == PH_IDLE))
		else $error("tick count left nonzero on return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (idx_q <= LAST_IDX))
		else $error("bit index past word length during transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_M_LOW || phase_q == PH_M_HIGH) |-> (tick_q != '0))
		else $error("master half counter is zero");

endmodule

// ===== src/serial_byte_exchange_port_core.sv =====
// Full-duplex serial byte exchange, MSB first, over data-out, data-in and clock pins.
// Each item on the input channel is one pin-sampling tick; every accepted item yields
// exactly one result showing pin drive levels and transfer status after that tick.
// Throughput is one item per clock cycle, and each result is registered: the transfer
// state is updated in a single pass per item and the result lands in an output
// register. A new item is taken whenever that register is empty or being read out
// in the same cycle; a result left waiting stalls the input until it is taken.
// Master or slave mode is latched at the start of a transfer; timing registers act
// at once. Registers sit on the APB port at 0x0 (master_mode), 0x4
// (half_period_ticks) and 0x8 (timeout_ticks) and should be written only while no
// transfer is in flight.
module serial_byte_exchange_port_core #(
	parameter int BITS_PER_BYTE = sbx_pkg::DEF_BITS_PER_BYTE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  sbx_pkg::item_t                   item,
	output logic                             res_valid,
	input  logic                             res_ready,
	output sbx_pkg::res_t                    res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sbx_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sbx_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sbx_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	sbx_pkg::cfg_t cfg;
	sbx_pkg::res_t res_d;
	sbx_pkg::res_t res_q;
	logic          res_valid_q;
	logic          step;

	assign item_ready = !res_valid_q || res_ready;
	assign step       = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	sbx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sbx_xfer_engine #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done_res) |-> !res_q.busy_res)
		else $error("transfer reported done while still busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.timed_out) |->
			(res_q.done_res && res_q.rx_byte == sbx_pkg::TIMEOUT_BYTE))
		else $error("timeout without done or timeout byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.done_res) |-> (res_q.rx_byte == 8'h00))
		else $error("received byte nonzero outside done");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.sck_drive) |-> res_q.busy_res)
		else $error("clock driven low while idle");

endmodule
